@@ design/ptie_pkg.sv @@
package ptie_pkg;

  localparam int KEY_W       = 64;
  localparam int TIME_W      = 48;
  localparam int LIMIT_W     = 32;
  localparam int FUNC_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int SLOT_W      = 4;
  localparam int MAX_RESULTS = 16;
  localparam int NEXP_W      = 5;
  localparam int ROW_W       = KEY_W + TIME_W;

  localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RESET = '1;

  localparam logic [FUNC_W-1:0] FUNC_CREATE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EXPIRE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EXPIRED      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE_EXPIRED = 3'd4;

  typedef enum logic [1:0] {
    EV_RESULT,
    EV_EXPIRED,
    EV_DONE
  } ptie_ev_kind_t;

  typedef struct packed {
    ptie_ev_kind_t         kind;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_W-1:0]     slot;
    logic [KEY_W-1:0]      key;
  } ptie_ev_t;

endpackage

@@ design/ptie_ram.sv @@
module ptie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/ptie_ctrl.sv @@
module ptie_ctrl #(
  parameter int TABLE_SLOTS = 16,
  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ptie_pkg::FUNC_W-1:0]  func,
  input  logic [ptie_pkg::KEY_W-1:0]   peer_key,
  input  logic [ptie_pkg::TIME_W-1:0]  now_ms,
  input  logic [ptie_pkg::LIMIT_W-1:0] idle_limit,
  output logic                      mem_we,
  output logic [IW-1:0]             mem_waddr,
  output logic [ptie_pkg::ROW_W-1:0]   mem_wdata,
  output logic [IW-1:0]             mem_raddr,
  input  logic [ptie_pkg::ROW_W-1:0]   mem_rdata,
  output logic                      ev_valid,
  input  logic                      ev_ready,
  output ptie_pkg::ptie_ev_t        ev
);

  import ptie_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                 state;
  logic [FUNC_W-1:0]      op;
  logic [KEY_W-1:0]       key_q;
  logic [TIME_W-1:0]      now_q;
  logic [IW-1:0]          idx;
  logic [NEXP_W-1:0]      nexp;
  logic [TABLE_SLOTS-1:0] valid_q;

  logic                   cur_valid;
  logic [KEY_W-1:0]       row_key;
  logic [TIME_W-1:0]      row_time;
  logic [TIME_W:0]        limit_sum;
  logic                   key_hit;
  logic                   idle_hit;
  logic                   at_end;
  logic                   advance;
  logic                   ev_fire;
  logic [IW+SLOT_W-1:0]   idx_ext;
  logic [SLOT_W-1:0]      cur_slot;

  assign cur_valid = valid_q[idx];
  assign row_key   = mem_rdata[ROW_W-1:TIME_W];
  assign row_time  = mem_rdata[TIME_W-1:0];
  assign limit_sum = {1'b0, row_time} + (TIME_W+1)'(idle_limit);
  assign key_hit   = cur_valid && (row_key == key_q);
  assign idle_hit  = cur_valid && (limit_sum < {1'b0, now_q}) &&
                     (nexp < NEXP_W'(MAX_RESULTS));
  assign at_end    = (idx == IW'(TABLE_SLOTS - 1));
  assign idx_ext   = {{SLOT_W{1'b0}}, idx};
  assign cur_slot  = idx_ext[SLOT_W-1:0];
  assign in_ready  = (state == S_IDLE);
  assign ev_fire   = ev_valid && ev_ready;

  always_comb begin
    ev_valid  = 1'b0;
    ev        = '0;
    ev.kind   = EV_RESULT;
    advance   = 1'b0;
    unique case (state)
      S_SCAN: begin
        unique case (op)
          FUNC_CREATE: begin
            if (!cur_valid) begin
              ev_valid  = 1'b1;
              ev.status = ST_OK;
              ev.slot   = cur_slot;
            end else if (at_end) begin
              ev_valid  = 1'b1;
              ev.status = ST_NO_FREE;
            end else begin
              advance = 1'b1;
            end
          end
          FUNC_FIND: begin
            if (key_hit) begin
              ev_valid  = 1'b1;
              ev.status = ST_OK;
              ev.slot   = cur_slot;
            end else if (at_end) begin
              ev_valid  = 1'b1;
              ev.status = ST_NOT_FOUND;
            end else begin
              advance = 1'b1;
            end
          end
          default: begin
            if (idle_hit) begin
              ev_valid  = 1'b1;
              ev.kind   = EV_EXPIRED;
              ev.status = ST_EXPIRED;
              ev.slot   = cur_slot;
              ev.key    = row_key;
              advance   = ev_ready && !at_end;
            end else begin
              advance = !at_end;
            end
          end
        endcase
      end
      S_DONE: begin
        ev_valid = 1'b1;
        ev.kind  = EV_DONE;
      end
      default: begin
        ev_valid = 1'b0;
      end
    endcase
  end

  assign mem_we    = (state == S_SCAN) && (op == FUNC_CREATE) && !cur_valid && ev_fire;
  assign mem_waddr = idx;
  assign mem_wdata = {key_q, now_q};
  assign mem_raddr = (state == S_IDLE) ? '0 : (advance ? idx + IW'(1) : idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      idx     <= '0;
      nexp    <= '0;
      valid_q <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && func != FUNC_UNUSED) begin
            state <= S_SCAN;
            op    <= func;
            key_q <= peer_key;
            now_q <= now_ms;
            idx   <= '0;
            nexp  <= '0;
          end
        end
        S_SCAN: begin
          if (advance) begin
            idx <= idx + IW'(1);
          end
          if (op == FUNC_CREATE || op == FUNC_FIND) begin
            if (ev_fire) begin
              state <= S_IDLE;
            end
            if (mem_we) begin
              valid_q[idx] <= 1'b1;
            end
          end else begin
            if (ev_fire) begin
              valid_q[idx] <= 1'b0;
              nexp         <= nexp + NEXP_W'(1);
            end
            if (at_end && (ev_fire || !idle_hit)) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (ev_fire) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ev_hold: assert property (@(posedge clk) disable iff (rst)
    ev_valid && !ev_ready |=> ev_valid && $stable(ev))
    else $error("event changed while stalled");

  a_nexp_cap: assert property (@(posedge clk) disable iff (rst)
    nexp <= NEXP_W'(MAX_RESULTS))
    else $error("expiry count past cap");

  a_create_marks: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> valid_q[$past(idx)])
    else $error("created slot not marked valid");

  a_expire_frees: assert property (@(posedge clk) disable iff (rst)
    ev_fire && ev.kind == EV_EXPIRED |=> !valid_q[$past(idx)])
    else $error("expired slot still valid");
`endif

endmodule

@@ design/ptie_outq.sv @@
module ptie_outq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         ev_valid,
  output logic                         ev_ready,
  input  ptie_pkg::ptie_ev_t           ev,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ptie_pkg::STATUS_W-1:0] status,
  output logic [ptie_pkg::SLOT_W-1:0]   slot,
  output logic [ptie_pkg::KEY_W-1:0]    expired_key,
  output logic                         last
);

  import ptie_pkg::*;

  logic                hold_valid;
  logic [SLOT_W-1:0]   hold_slot;
  logic [KEY_W-1:0]    hold_key;

  logic                fire;
  logic                push;
  logic [STATUS_W-1:0] status_next;
  logic [SLOT_W-1:0]   slot_next;
  logic [KEY_W-1:0]    key_next;
  logic                last_next;

  assign ev_ready = !out_valid || out_ready;
  assign fire     = ev_valid && ev_ready;

  always_comb begin
    push        = 1'b0;
    status_next = ev.status;
    slot_next   = ev.slot;
    key_next    = '0;
    last_next   = 1'b1;
    if (fire) begin
      unique case (ev.kind)
        EV_RESULT: begin
          push = 1'b1;
        end
        EV_EXPIRED: begin
          push        = hold_valid;
          status_next = ST_EXPIRED;
          slot_next   = hold_slot;
          key_next    = hold_key;
          last_next   = 1'b0;
        end
        EV_DONE: begin
          push = 1'b1;
          if (hold_valid) begin
            status_next = ST_EXPIRED;
            slot_next   = hold_slot;
            key_next    = hold_key;
          end else begin
            status_next = ST_NONE_EXPIRED;
            slot_next   = '0;
          end
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (push) begin
        out_valid   <= 1'b1;
        status      <= status_next;
        slot        <= slot_next;
        expired_key <= key_next;
        last        <= last_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (fire && ev.kind == EV_EXPIRED) begin
        hold_valid <= 1'b1;
        hold_slot  <= ev.slot;
        hold_key   <= ev.key;
      end else if (fire && ev.kind == EV_DONE) begin
        hold_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_hold_on_result: assert property (@(posedge clk) disable iff (rst)
    fire && ev.kind == EV_RESULT |-> !hold_valid)
    else $error("held expiry during single result");

  a_single_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_EXPIRED |-> last && expired_key == '0)
    else $error("non-expiry result not final");
`endif

endmodule

@@ design/peer_table_with_idle_expiry.sv @@
// Peer table with idle expiry.
// Input channel (in_valid/in_ready): func, peer_key, now_ms. Create claims
// the lowest free slot, find returns the lowest valid slot holding peer_key,
// expire frees every valid slot idle longer than idle_limit. func 3 is taken
// and dropped without a result, and the input is free again the next cycle.
// Output channel (out_valid/out_ready): status, slot, expired_key, last. Each
// item gives one result, except expire, which gives one per freed slot (at
// most 16, lowest slots first, last on the final one) or one if none expire.
// Keys and times sit in a one-port-read RAM with registered read; the scan
// walks it one slot per cycle while the receiver keeps up, so an item's
// final result is registered once the scan finds its slot or reaches the end
// (expire always scans to the end); the next item is taken once that result
// is in the result register. Expiry results trail the scan by one freed slot.
// idle_limit_we loads idle_limit from idle_limit_wdata; write it only when idle.
// Reset frees every slot and sets idle_limit to all ones; no clearing pass.
// When the receiver stalls, the result register holds and the scan waits at the next slot with a result to hand on.
module peer_table_with_idle_expiry #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ptie_pkg::FUNC_W-1:0]   func,
  input  logic [ptie_pkg::KEY_W-1:0]    peer_key,
  input  logic [ptie_pkg::TIME_W-1:0]   now_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ptie_pkg::STATUS_W-1:0] status,
  output logic [ptie_pkg::SLOT_W-1:0]   slot,
  output logic [ptie_pkg::KEY_W-1:0]    expired_key,
  output logic                          last,
  input  logic                          idle_limit_we,
  input  logic [ptie_pkg::LIMIT_W-1:0]  idle_limit_wdata
);

  import ptie_pkg::*;

  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  logic [LIMIT_W-1:0] idle_limit;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [ROW_W-1:0]   mem_wdata;
  logic [IW-1:0]      mem_raddr;
  logic [ROW_W-1:0]   mem_rdata;
  logic               ev_valid;
  logic               ev_ready;
  ptie_ev_t           ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_limit <= IDLE_LIMIT_RESET;
    end else if (idle_limit_we) begin
      idle_limit <= idle_limit_wdata;
    end
  end

  ptie_ram #(
    .WIDTH (ROW_W),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ptie_ctrl #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .peer_key   (peer_key),
    .now_ms     (now_ms),
    .idle_limit (idle_limit),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .ev_valid   (ev_valid),
    .ev_ready   (ev_ready),
    .ev         (ev)
  );

  ptie_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .ev_valid    (ev_valid),
    .ev_ready    (ev_ready),
    .ev          (ev),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .slot        (slot),
    .expired_key (expired_key),
    .last        (last)
  );

`ifndef SYNTHESIS
  a_idle_between_items: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func != FUNC_UNUSED |=> !in_ready)
    else $error("second item taken during scan");

  a_limit_write: assert property (@(posedge clk) disable iff (rst)
    idle_limit_we |=> idle_limit == $past(idle_limit_wdata))
    else $error("idle_limit write lost");

  a_out_last_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> status == ST_EXPIRED)
    else $error("non-final result that is not an expiry");
`endif

endmodule

@@ verif/peer_table_checker.sv @@
module peer_table_checker #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [ptie_pkg::FUNC_W-1:0]   func,
  input  logic [ptie_pkg::KEY_W-1:0]    peer_key,
  input  logic [ptie_pkg::TIME_W-1:0]   now_ms,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [ptie_pkg::STATUS_W-1:0] status,
  input  logic [ptie_pkg::SLOT_W-1:0]   slot,
  input  logic [ptie_pkg::KEY_W-1:0]    expired_key,
  input  logic                          last,
  input  logic                          idle_limit_we,
  input  logic [ptie_pkg::LIMIT_W-1:0]  idle_limit_wdata,
  output int                            mismatches,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import ptie_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [KEY_W-1:0]    key;
    logic                last;
  } peer_reply_t;

  peer_reply_t        replies_due[$];
  logic               table_used [TABLE_SLOTS];
  logic [KEY_W-1:0]   table_key  [TABLE_SLOTS];
  logic [TIME_W-1:0]  table_seen [TABLE_SLOTS];
  logic [LIMIT_W-1:0] limit_ms;
  int                 fail_total = 0;

  function automatic void apply_request(input logic [FUNC_W-1:0] f,
                                        input logic [KEY_W-1:0] k,
                                        input logic [TIME_W-1:0] t);
    peer_reply_t     r;
    int              freed;
    logic [TIME_W:0] deadline;
    r = '0;
    r.last = 1'b1;
    case (f)
      FUNC_CREATE: begin
        r.status = ST_NO_FREE;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (!table_used[i]) begin
            table_used[i] = 1'b1;
            table_key[i] = k;
            table_seen[i] = t;
            r.status = ST_OK;
            r.slot = SLOT_W'(i);
            break;
          end
        end
        replies_due.push_back(r);
      end
      FUNC_FIND: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (table_used[i] && table_key[i] == k) begin
            r.status = ST_OK;
            r.slot = SLOT_W'(i);
            break;
          end
        end
        replies_due.push_back(r);
      end
      FUNC_EXPIRE: begin
        freed = 0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          deadline = {1'b0, table_seen[i]} + (TIME_W+1)'(limit_ms);
          if (freed < MAX_RESULTS && table_used[i] && deadline < {1'b0, t}) begin
            r.status = ST_EXPIRED;
            r.slot = SLOT_W'(i);
            r.key = table_key[i];
            r.last = 1'b0;
            replies_due.push_back(r);
            table_used[i] = 1'b0;
            freed++;
          end
        end
        if (freed == 0) begin
          r = '0;
          r.status = ST_NONE_EXPIRED;
          r.last = 1'b1;
          replies_due.push_back(r);
        end else begin
          r = replies_due.pop_back();
          r.last = 1'b1;
          replies_due.push_back(r);
        end
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin : watch
    peer_reply_t want;
    if (rst) begin
      replies_due.delete();
      limit_ms = IDLE_LIMIT_RESET;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        table_used[i] = 1'b0;
        table_key[i] = '0;
        table_seen[i] = '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          if (fail_total < 10) begin
            $display("%0t: result with none due: status %0d slot %0d key %h last %b",
                     $realtime, status, slot, expired_key, last);
          end
          fail_total++;
        end else begin
          want = replies_due.pop_front();
          if (status !== want.status || slot !== want.slot ||
              expired_key !== want.key || last !== want.last) begin
            if (fail_total < 10) begin
              $display("%0t: expected status %0d slot %0d key %h last %b",
                       $realtime, want.status, want.slot, want.key, want.last);
              $display("%0t:      got status %0d slot %0d key %h last %b",
                       $realtime, status, slot, expired_key, last);
            end
            fail_total++;
          end
        end
      end
      if (idle_limit_we) begin
        limit_ms = idle_limit_wdata;
      end
      if (in_valid && in_ready) begin
        apply_request(func, peer_key, now_ms);
      end
    end
    pending <= replies_due.size();
    mismatches <= fail_total;
  end

endmodule

@@ verif/tb_peer_table_with_idle_expiry.sv @@
module tb_peer_table_with_idle_expiry;
  timeunit 1ns;
  timeprecision 1ps;

  import ptie_pkg::*;

  localparam int TABLE_SLOTS = 16;
  localparam logic [TIME_W-1:0] NEAR_MAX = 48'hFFFF_8000_0000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [FUNC_W-1:0]   func = FUNC_CREATE;
  logic [KEY_W-1:0]    peer_key = '0;
  logic [TIME_W-1:0]   now_ms = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [KEY_W-1:0]    expired_key;
  logic                last;
  logic                idle_limit_we = 1'b0;
  logic [LIMIT_W-1:0]  idle_limit_wdata = '0;
  int                  mismatches;
  int                  pending;

  int                  burst_left = 0;
  bit                  gaps_on = 1'b1;
  bit                  long_hold_go = 1'b0;
  logic [TIME_W-1:0]   t_ms;
  logic [KEY_W-1:0]    key_pool [8];

  peer_table_with_idle_expiry #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .peer_key(peer_key),
    .now_ms(now_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .slot(slot),
    .expired_key(expired_key),
    .last(last),
    .idle_limit_we(idle_limit_we),
    .idle_limit_wdata(idle_limit_wdata)
  );

  peer_table_checker #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) table_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("peer_table_with_idle_expiry verification failed");
    $finish;
  end

  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    bit hold_done;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  // enter and leave at a falling edge
  task automatic offer_transfer(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                                input logic [TIME_W-1:0] t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_on ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    func <= f;
    peer_key <= k;
    now_ms <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_idle_limit(input logic [LIMIT_W-1:0] value);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TABLE_SLOTS + 4) @(negedge clk);
    idle_limit_we <= 1'b1;
    idle_limit_wdata <= value;
    @(negedge clk);
    idle_limit_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [LIMIT_W-1:0] limit, input int count, input bit squeeze);
    int pick;
    logic [KEY_W-1:0] k;
    set_idle_limit(limit);
    if (squeeze) begin
      long_hold_go = 1'b1;
    end
    gaps_on = ($urandom_range(0, 3) != 0);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 11) == 0) begin
        t_ms = t_ms + ((48'd1 << $urandom_range(4, 34)) | 48'($urandom));
      end else if ($urandom_range(0, 19) == 0) begin
        t_ms = t_ms - 48'($urandom_range(1, 30));
      end else begin
        t_ms = t_ms + 48'($urandom_range(0, 6));
      end
      if ($urandom_range(0, 7) == 0) begin
        key_pool[$urandom_range(0, 7)] = {$urandom, $urandom};
      end
      k = key_pool[$urandom_range(0, 7)];
      if (pick < 40) begin
        offer_transfer(FUNC_CREATE, k, t_ms);
      end else if (pick < 70) begin
        offer_transfer(FUNC_FIND, ($urandom_range(0, 4) == 0) ? {$urandom, $urandom} : k, t_ms);
      end else if (pick < 95) begin
        offer_transfer(FUNC_EXPIRE, {$urandom, $urandom}, t_ms);
      end else begin
        offer_transfer(FUNC_UNUSED, {$urandom, $urandom}, 48'({$urandom, $urandom}));
      end
    end
  endtask

  initial begin : stimulus
    for (int i = 0; i < 8; i++) begin
      key_pool[i] = {$urandom, $urandom};
    end
    t_ms = 48'({$urandom, $urandom});
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    offer_transfer(FUNC_UNUSED, {$urandom, $urandom}, 48'({$urandom, $urandom}));
    offer_transfer(FUNC_FIND, {$urandom, $urandom}, 48'd7);
    offer_transfer(FUNC_EXPIRE, '0, '0);
    offer_transfer(FUNC_CREATE, '0, '0);
    offer_transfer(FUNC_CREATE, '1, NEAR_MAX);
    offer_transfer(FUNC_CREATE, '1, 48'd5);
    offer_transfer(FUNC_FIND, '1, 48'd6);
    offer_transfer(FUNC_EXPIRE, {$urandom, $urandom}, '1);
    offer_transfer(FUNC_FIND, '0, '1);
    offer_transfer(FUNC_FIND, '1, '1);
    for (int i = 0; i < TABLE_SLOTS - 1; i++) begin
      offer_transfer(FUNC_CREATE, {$urandom, $urandom}, 48'(100 + i));
    end
    offer_transfer(FUNC_CREATE, {$urandom, $urandom}, 48'd200);
    set_idle_limit('0);
    offer_transfer(FUNC_EXPIRE, {$urandom, $urandom}, '1);

    run_phase(LIMIT_W'($urandom_range(1, 40)), 49, 1'b1);
    run_phase('1, 49, 1'b0);
    run_phase(LIMIT_W'($urandom), 49, 1'b0);
    run_phase('0, 49, 1'b0);
    run_phase(LIMIT_W'($urandom_range(2, 80)), 49, 1'b0);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2 * TABLE_SLOTS + 8) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("peer_table_with_idle_expiry verification clean");
    end else begin
      $display("peer_table_with_idle_expiry verification failed");
    end
    $finish;
  end

endmodule

@@ peer_table_with_idle_expiry.f @@
design/ptie_pkg.sv
design/ptie_ram.sv
design/ptie_ctrl.sv
design/ptie_outq.sv
design/peer_table_with_idle_expiry.sv
verif/peer_table_checker.sv
verif/tb_peer_table_with_idle_expiry.sv
